// File: src/ppts_pkg.sv
// Package: task table sizes, item and entry types, sequencer states.
`timescale 1ns / 1ps
package ppts_pkg;

  localparam int unsigned TASK_SLOTS = 16;
  localparam int unsigned SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(TASK_SLOTS + 1);
  localparam logic [15:0] TIME_MAX   = 16'hFFFF;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DRAIN,
    S_TICK
  } state_e;

  typedef struct packed {
    logic        command;
    logic [15:0] new_id;
    logic [7:0]  new_priority;
    logic [15:0] new_arrival;
    logic [15:0] new_burst;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        ran;
    logic [15:0] running_id;
    logic        switched;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] waiting;
    logic        all_done;
    logic [15:0] time_now;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] remaining;
  } entry_t;

  // write request into the task table
  typedef struct packed {
    logic              en;
    logic              add;
    logic [SLOT_W-1:0] idx;
    entry_t            entry;
  } tbl_wr_t;

endpackage

// File: src/ppts_if.sv
// Interfaces: command channel and result channel.
`timescale 1ns / 1ps
interface ppts_cmd_if;
  logic             valid;
  logic             ready;
  ppts_pkg::cmd_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppts_res_if;
  logic             valid;
  logic             ready;
  ppts_pkg::res_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/preemptive_priority_task_scheduler.sv
// Top level: preemptive priority task scheduler with a sequential slot scan.
`timescale 1ns / 1ps
// An add item stores a task in the next unused slot (slots fill in order and
// are never reused); its result is registered in S_ADD once the output
// register is free. A tick item scans every slot through the table's single
// read port, one slot per cycle, with one shared priority compare, then goes
// through S_DRAIN and S_TICK, where its result is registered. One item is
// worked on at a time; a new item is accepted while the previous result still
// waits in the output register, but its result waits for that register.
module preemptive_priority_task_scheduler (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppts_cmd_if.sink   cmd_i,
  ppts_res_if.source res_o
);

  localparam logic [ppts_pkg::SLOT_W-1:0] LAST_SLOT =
    ppts_pkg::SLOT_W'(ppts_pkg::TASK_SLOTS - 1);

  ppts_pkg::state_e               state_q, state_d;
  ppts_pkg::cmd_t                 cmd_q;
  logic [15:0]                    clock_q, clock_d;
  logic [ppts_pkg::SLOT_W-1:0]    last_slot_q, last_slot_d;
  logic                           last_valid_q, last_valid_d;
  logic [ppts_pkg::SLOT_W-1:0]    scan_q, scan_d;
  logic                           rd_valid_q, rd_valid_d;
  logic [ppts_pkg::SLOT_W-1:0]    rd_idx_q;
  logic                           found_q, found_d;
  logic [ppts_pkg::SLOT_W-1:0]    best_idx_q, best_idx_d;
  ppts_pkg::entry_t               best_q, best_d;
  logic                           out_valid_q, out_valid_d;
  ppts_pkg::res_t                 out_q, out_d;

  ppts_pkg::tbl_wr_t               tbl_wr;
  ppts_pkg::entry_t                rdata;
  logic [ppts_pkg::TASK_SLOTS-1:0] busy;
  logic [ppts_pkg::CNT_W-1:0]      fill;
  logic [ppts_pkg::TASK_SLOTS-1:0] busy_after;

  logic        in_fire;
  logic        out_free;
  logic        table_full;
  logic        eligible;
  logic        take;
  logic [15:0] clock_inc;
  logic [15:0] rem_new;
  logic        fin;
  logic [15:0] tat;
  logic [15:0] wt;

  ppts_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (tbl_wr),
    .raddr_i (scan_q),
    .rdata_o (rdata),
    .busy_o  (busy),
    .fill_o  (fill)
  );

  assign cmd_i.ready = (state_q == ppts_pkg::S_IDLE);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;
  assign table_full  = (fill == ppts_pkg::CNT_W'(ppts_pkg::TASK_SLOTS));

  // shared compare: one slot per cycle against the best so far
  assign eligible = rd_valid_q && busy[rd_idx_q] && (rdata.arrival <= clock_q);
  assign take     = eligible && (!found_q || (rdata.prio < best_q.prio));

  assign clock_inc = (clock_q == ppts_pkg::TIME_MAX) ? clock_q : clock_q + 16'd1;
  assign rem_new   = best_q.remaining - 16'd1;
  assign fin       = found_q && (rem_new == 16'd0);
  assign tat       = clock_inc - best_q.arrival;
  assign wt        = (tat >= best_q.burst) ? (tat - best_q.burst) : 16'd0;

  always_comb begin
    state_d      = state_q;
    clock_d      = clock_q;
    last_slot_d  = last_slot_q;
    last_valid_d = last_valid_q;
    scan_d       = scan_q;
    rd_valid_d   = 1'b0;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_d        = out_q;
    busy_after   = busy;
    tbl_wr       = '0;

    if (take) begin
      found_d    = 1'b1;
      best_idx_d = rd_idx_q;
      best_d     = rdata;
    end

    case (state_q)
      ppts_pkg::S_IDLE: begin
        if (in_fire) begin
          scan_d  = '0;
          found_d = 1'b0;
          state_d = (cmd_i.data.command == ppts_pkg::CMD_TICK) ?
                    ppts_pkg::S_SCAN : ppts_pkg::S_ADD;
        end
      end
      ppts_pkg::S_ADD: begin
        if (out_free) begin
          if (!table_full) begin
            tbl_wr.en              = 1'b1;
            tbl_wr.add             = 1'b1;
            tbl_wr.idx             = fill[ppts_pkg::SLOT_W-1:0];
            tbl_wr.entry.id        = cmd_q.new_id;
            tbl_wr.entry.prio      = cmd_q.new_priority;
            tbl_wr.entry.arrival   = cmd_q.new_arrival;
            tbl_wr.entry.burst     = cmd_q.new_burst;
            tbl_wr.entry.remaining = cmd_q.new_burst;
            busy_after[fill[ppts_pkg::SLOT_W-1:0]] = (cmd_q.new_burst != 16'd0);
          end
          out_d          = '0;
          out_d.status   = table_full ? ppts_pkg::ST_FULL : ppts_pkg::ST_OK;
          out_d.all_done = ~|busy_after;
          out_d.time_now = clock_q;
          out_valid_d    = 1'b1;
          state_d        = ppts_pkg::S_IDLE;
        end
      end
      ppts_pkg::S_SCAN: begin
        rd_valid_d = 1'b1;
        scan_d     = scan_q + ppts_pkg::SLOT_W'(1);
        if (scan_q == LAST_SLOT) begin
          state_d = ppts_pkg::S_DRAIN;
        end
      end
      ppts_pkg::S_DRAIN: begin
        // compare of the last slot happens this cycle
        state_d = ppts_pkg::S_TICK;
      end
      ppts_pkg::S_TICK: begin
        if (out_free) begin
          clock_d = clock_inc;
          out_d   = '0;
          if (found_q) begin
            tbl_wr.en              = 1'b1;
            tbl_wr.idx             = best_idx_q;
            tbl_wr.entry           = best_q;
            tbl_wr.entry.remaining = rem_new;
            if (fin) begin
              busy_after[best_idx_q] = 1'b0;
            end
            out_d.ran        = 1'b1;
            out_d.running_id = best_q.id;
            out_d.switched   = !last_valid_q || (last_slot_q != best_idx_q);
            out_d.finished   = fin;
            out_d.turnaround = fin ? tat : 16'd0;
            out_d.waiting    = fin ? wt : 16'd0;
            last_slot_d      = best_idx_q;
            last_valid_d     = 1'b1;
          end
          out_d.status   = ppts_pkg::ST_OK;
          out_d.all_done = ~|busy_after;
          out_d.time_now = clock_inc;
          out_valid_d    = 1'b1;
          state_d        = ppts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ppts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ppts_pkg::S_IDLE;
      clock_q      <= '0;
      last_slot_q  <= '0;
      last_valid_q <= 1'b0;
      scan_q       <= '0;
      rd_valid_q   <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clock_q      <= clock_d;
      last_slot_q  <= last_slot_d;
      last_valid_q <= last_valid_d;
      scan_q       <= scan_d;
      rd_valid_q   <= rd_valid_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= cmd_i.data;
    end
    rd_idx_q   <= scan_q;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    out_q      <= out_d;
  end

endmodule

// File: src/ppts_table.sv
// Task table: entry memory with registered read, busy flags and fill count.
`timescale 1ns / 1ps
module ppts_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ppts_pkg::tbl_wr_t               wr_i,
  input  logic [ppts_pkg::SLOT_W-1:0]     raddr_i,
  output ppts_pkg::entry_t                rdata_o,
  output logic [ppts_pkg::TASK_SLOTS-1:0] busy_o,
  output logic [ppts_pkg::CNT_W-1:0]      fill_o
);

  ppts_pkg::entry_t                mem_q [ppts_pkg::TASK_SLOTS];
  ppts_pkg::entry_t                rdata_q;
  logic [ppts_pkg::TASK_SLOTS-1:0] busy_q;
  logic [ppts_pkg::CNT_W-1:0]      fill_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.entry;
    end
    rdata_q <= mem_q[raddr_i];
  end

  // slots fill in order and are never freed, so used == below fill count;
  // busy marks used slots with work left
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
      fill_q <= '0;
    end else if (wr_i.en) begin
      busy_q[wr_i.idx] <= (wr_i.entry.remaining != 16'd0);
      if (wr_i.add) begin
        fill_q <= fill_q + ppts_pkg::CNT_W'(1);
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;
  assign fill_o  = fill_q;

endmodule

// File: test/tb_top.sv
// Testbench for the preemptive priority task scheduler: directed table, then random items.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned DIR_N          = 28;
  localparam int unsigned RAND_PER_PHASE = 175;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int          IDLE_PCT  [4]  = '{0, 73, 0, 38};
  localparam int          STALL_PCT [4]  = '{0, 0, 73, 38};

  typedef struct packed {
    ppts_pkg::cmd_t item;
    logic           typed;
    ppts_pkg::res_t want;
  } dir_row_t;

  // Rows with typed = 1 carry their result; the others are checked by the predictor.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // idle tick on an empty table
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b1,
      '{ppts_pkg::ST_OK, 1'b0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b1, 16'd1}},
    // late task, slot 0: never arrives, so work stays pending
    '{'{ppts_pkg::CMD_ADD, 16'hA5A5, 8'd0, 16'd65530, 16'd10}, 1'b1,
      '{ppts_pkg::ST_OK, 1'b0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 16'd1}},
    // zero burst: stored, never runs
    '{'{ppts_pkg::CMD_ADD, 16'h0000, 8'd255, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h1111, 8'd200, 16'd0, 16'd5}, 1'b0, '0},
    // first run since reset
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h2222, 8'd10, 16'd4, 16'd2}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    // 0x2222 arrives and preempts
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    // equal priorities: lower slot wins
    '{'{ppts_pkg::CMD_ADD, 16'h3333, 8'd50, 16'd0, 16'd2}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h4444, 8'd50, 16'd0, 16'd1}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{ppts_pkg::CMD_TICK, 16'h0000, 8'd0, 16'd0, 16'd0}, 1'b0, '0},
    // all-ones task: arrives only at the last time unit
    '{'{ppts_pkg::CMD_ADD, 16'hFFFF, 8'd255, 16'd65535, 16'd65535}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h0101, 8'd128, 16'd20, 16'd30}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h0202, 8'd64, 16'd40, 16'd12}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h0303, 8'd64, 16'd45, 16'd8}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h8000, 8'd1, 16'd60, 16'd5}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h7FFF, 8'd254, 16'd330, 16'd40}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h0C0C, 8'd100, 16'd250, 16'd25}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h0D0D, 8'd32, 16'd260, 16'd6}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h0E0E, 8'd100, 16'd300, 16'd20}, 1'b0, '0},
    '{'{ppts_pkg::CMD_ADD, 16'h00F0, 8'd3, 16'd420, 16'd10}, 1'b0, '0},
    // table full
    '{'{ppts_pkg::CMD_ADD, 16'h5A5A, 8'd7, 16'd12, 16'd9}, 1'b1,
      '{ppts_pkg::ST_FULL, 1'b0, 16'h0, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0, 16'd11}}
  };

  logic clk;
  logic rst_n;

  ppts_cmd_if cmd_if ();
  ppts_res_if res_if ();

  preemptive_priority_task_scheduler dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // scheduler shadow state
  logic                        slot_busy [ppts_pkg::TASK_SLOTS] = '{default: 1'b0};
  ppts_pkg::entry_t            task_tab  [ppts_pkg::TASK_SLOTS];
  logic [15:0]                 model_time = '0;
  logic [ppts_pkg::SLOT_W-1:0] last_idx   = '0;
  logic                        last_ran   = 1'b0;

  ppts_pkg::res_t pending_results [$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  logic hold_off   = 1'b0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int mismatch_cnt = 0;
  int run_cnt      = 0;
  int switch_cnt   = 0;
  int finish_cnt   = 0;
  int clamp_cnt    = 0;
  int full_cnt     = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic predict_schedule(input ppts_pkg::cmd_t c, output ppts_pkg::res_t r);
    int          pick;
    logic [15:0] span;
    r    = '0;
    pick = -1;
    if (c.command == ppts_pkg::CMD_ADD) begin
      for (int i = 0; i < ppts_pkg::TASK_SLOTS; i++) begin
        if (!slot_busy[i] && pick < 0) pick = i;
      end
      if (pick < 0) begin
        r.status = ppts_pkg::ST_FULL;
        full_cnt++;
      end else begin
        slot_busy[pick]          = 1'b1;
        task_tab[pick].id        = c.new_id;
        task_tab[pick].prio      = c.new_priority;
        task_tab[pick].arrival   = c.new_arrival;
        task_tab[pick].burst     = c.new_burst;
        task_tab[pick].remaining = c.new_burst;
      end
    end else begin
      for (int i = 0; i < ppts_pkg::TASK_SLOTS; i++) begin
        if (slot_busy[i] && task_tab[i].arrival <= model_time &&
            task_tab[i].remaining != 0) begin
          if (pick < 0 || task_tab[i].prio < task_tab[pick].prio) pick = i;
        end
      end
      if (model_time != ppts_pkg::TIME_MAX) model_time = model_time + 16'd1;
      if (pick >= 0) begin
        r.ran        = 1'b1;
        r.running_id = task_tab[pick].id;
        r.switched   = !last_ran || last_idx != ppts_pkg::SLOT_W'(pick);
        last_idx     = ppts_pkg::SLOT_W'(pick);
        last_ran     = 1'b1;
        run_cnt++;
        if (r.switched) switch_cnt++;
        task_tab[pick].remaining = task_tab[pick].remaining - 16'd1;
        if (task_tab[pick].remaining == 0) begin
          // the task only ran once arrived, so this cannot wrap
          span         = model_time - task_tab[pick].arrival;
          r.finished   = 1'b1;
          r.turnaround = span;
          if (span >= task_tab[pick].burst) begin
            r.waiting = span - task_tab[pick].burst;
          end else begin
            clamp_cnt++;
          end
          finish_cnt++;
        end
      end
    end
    r.all_done = 1'b1;
    for (int i = 0; i < ppts_pkg::TASK_SLOTS; i++) begin
      if (slot_busy[i] && task_tab[i].remaining != 0) r.all_done = 1'b0;
    end
    r.time_now = model_time;
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: result %0d: %s got %h expected %h", $time, results_seen, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result(input ppts_pkg::res_t got);
    ppts_pkg::res_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("no result pending, time_now", got.time_now, '0);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 16'(got.status), 16'(want.status));
      if (got.ran !== want.ran) report_mismatch("ran", 16'(got.ran), 16'(want.ran));
      if (got.running_id !== want.running_id)
        report_mismatch("running_id", got.running_id, want.running_id);
      if (got.switched !== want.switched)
        report_mismatch("switched", 16'(got.switched), 16'(want.switched));
      if (got.finished !== want.finished)
        report_mismatch("finished", 16'(got.finished), 16'(want.finished));
      if (got.turnaround !== want.turnaround)
        report_mismatch("turnaround", got.turnaround, want.turnaround);
      if (got.waiting !== want.waiting) report_mismatch("waiting", got.waiting, want.waiting);
      if (got.all_done !== want.all_done)
        report_mismatch("all_done", 16'(got.all_done), 16'(want.all_done));
      if (got.time_now !== want.time_now)
        report_mismatch("time_now", got.time_now, want.time_now);
    end
  endtask

  function automatic ppts_pkg::cmd_t random_item(input bit is_add);
    ppts_pkg::cmd_t c;
    c.command      = is_add ? ppts_pkg::CMD_ADD : ppts_pkg::CMD_TICK;
    c.new_id       = 16'($urandom);
    c.new_priority = 8'($urandom);
    c.new_arrival  = 16'($urandom);
    c.new_burst    = 16'($urandom);
    return c;
  endfunction

  task automatic offer_item(input ppts_pkg::cmd_t item, input bit typed,
                            input ppts_pkg::res_t want);
    ppts_pkg::res_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= item;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_schedule(item, predicted);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    accepted_cnt++;
  endtask

  // result side: check what was taken at this edge, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) check_result(res_if.data);
    res_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off while the sender keeps offering, to back the block up
  initial begin
    while (accepted_cnt < DIR_N + 60) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #50_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    res_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      offer_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // table is full from here on: mostly ticks, some refused adds as noise
    for (int p = 0; p < 4; p++) begin
      idle_pct  <= IDLE_PCT[p];
      stall_pct <= STALL_PCT[p];
      repeat (RAND_PER_PHASE) offer_item(random_item($urandom_range(99) < 15), 1'b0, '0);
    end

    idle_pct  <= 0;
    stall_pct <= 0;
    cmd_if.valid <= 1'b0;

    for (int n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never came, count", 16'(pending_results.size()), '0);

    $display("summary: %0d items (%0d directed), %0d task runs, %0d switches, %0d completions",
             accepted_cnt, DIR_N, run_cnt, switch_cnt, finish_cnt);
    $display("summary: %0d refused adds, %0d clamped waits, final time %0d, %0d mismatches",
             full_cnt, clamp_cnt, model_time, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/ppts_pkg.sv
src/ppts_if.sv
src/ppts_table.sv
src/preemptive_priority_task_scheduler.sv
test/tb_top.sv
